// ----- rtl/core/tpmd_pkg.sv -----
package tpmd_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int FRAC_BITS_DEF    = 16;
  localparam int TABLE_BITS       = 24;
  localparam int SAMPLE_W         = 16;
  localparam int GAIN_W           = 16;
  localparam int TARGET_W         = 17;
  localparam int FLOOR_W          = 8;
  localparam int STATE_W          = 32;
  localparam int DER_W            = 41;
  localparam int SUM_W            = 60;
  localparam int WIDE_W           = 48;
  localparam int DEN_W            = 15;
  localparam int CFG_IDX_W        = 3;
  localparam int CFG_DATA_W       = 17;

  localparam logic [DEN_W-1:0] DIV_GYRO  = 15'd26200;
  localparam logic [DEN_W-1:0] DIV_BLEND = 15'd50;
  localparam logic [DEN_W-1:0] DIV_INTEG = 15'd200;

  localparam logic [GAIN_W-1:0]   GAIN_P_RST = 16'd25600;
  localparam logic [GAIN_W-1:0]   GAIN_I_RST = 16'd256;
  localparam logic [GAIN_W-1:0]   GAIN_D_RST = 16'd256;
  localparam logic [FLOOR_W-1:0]  FLOOR_RST  = 8'd5;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_P       = 3'd0,
    REG_GAIN_I       = 3'd1,
    REG_GAIN_D       = 3'd2,
    REG_TARGET_ANGLE = 3'd3,
    REG_PWM_FLOOR    = 3'd4
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CORDIC,
    ST_GYRO,
    ST_BLEND,
    ST_ERR,
    ST_INTEG,
    ST_MUL,
    ST_OUT
  } tpmd_state_t;

  // atan(2^-i) in degrees, Q8.24
  function automatic logic [31:0] atan_deg_q24(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'd754974720;
      5'd1:  v = 32'd445687602;
      5'd2:  v = 32'd235489088;
      5'd3:  v = 32'd119537938;
      5'd4:  v = 32'd60000934;
      5'd5:  v = 32'd30029717;
      5'd6:  v = 32'd15018523;
      5'd7:  v = 32'd7509720;
      5'd8:  v = 32'd3754917;
      5'd9:  v = 32'd1877466;
      5'd10: v = 32'd938734;
      5'd11: v = 32'd469367;
      5'd12: v = 32'd234684;
      5'd13: v = 32'd117342;
      5'd14: v = 32'd58671;
      5'd15: v = 32'd29335;
      5'd16: v = 32'd14668;
      5'd17: v = 32'd7334;
      5'd18: v = 32'd3667;
      5'd19: v = 32'd1833;
      5'd20: v = 32'd917;
      5'd21: v = 32'd458;
      5'd22: v = 32'd229;
      5'd23: v = 32'd115;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [STATE_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] lo;
    hi = WIDE_W'(32'sh7fffffff);
    lo = -hi - WIDE_W'(1);
    if (v > hi) return hi[STATE_W-1:0];
    if (v < lo) return lo[STATE_W-1:0];
    return v[STATE_W-1:0];
  endfunction

endpackage

// ----- rtl/core/tpmd_cordic.sv -----
module tpmd_cordic
  import tpmd_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
  parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic signed [SAMPLE_W-1:0]    ax,
  input  logic signed [SAMPLE_W-1:0]    az,
  output logic                          done,
  output logic signed [FRAC_BITS+9:0]   z
);

  localparam int ZW   = FRAC_BITS + 10;
  localparam int CW   = SAMPLE_W + TABLE_BITS + 3;
  localparam int CNTW = $clog2(CORDIC_STEPS);
  localparam int SH   = TABLE_BITS - FRAC_BITS;
  localparam logic [32:0] HALF = (33'd1 << SH) >> 1;
  localparam logic signed [ZW-1:0] QUARTER = ZW'(90) <<< FRAC_BITS;

  logic signed [CW-1:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [ZW-1:0] z_r, z_nxt;
  logic [CNTW-1:0]      cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt, done_r, done_nxt, zero_r, zero_nxt;
  logic signed [17:0]   px, py;
  logic signed [ZW-1:0] pz;
  logic [32:0]          ang_full;
  logic signed [ZW-1:0] ang;
  logic signed [CW-1:0] xs, ys;

  always_comb begin
    px = 18'(az);
    py = 18'(ax);
    pz = '0;
    if (az < 0) begin
      if (ax >= 0) begin
        px = 18'(ax);
        py = -18'(az);
        pz = QUARTER;
      end else begin
        px = -18'(ax);
        py = 18'(az);
        pz = -QUARTER;
      end
    end
  end

  assign ang_full = ({1'b0, atan_deg_q24(5'(cnt_r))} + HALF) >> SH;
  assign ang      = signed'(ZW'(ang_full));
  assign xs       = x_r >>> cnt_r;
  assign ys       = y_r >>> cnt_r;

  always_comb begin
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    zero_nxt = zero_r;
    if (start) begin
      x_nxt    = CW'(px) <<< TABLE_BITS;
      y_nxt    = CW'(py) <<< TABLE_BITS;
      z_nxt    = pz;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
      zero_nxt = (ax == 0) && (az == 0);
    end else if (busy_r) begin
      if (!y_r[CW-1]) begin
        x_nxt = x_r + ys;
        y_nxt = y_r - xs;
        z_nxt = z_r + ang;
      end else begin
        x_nxt = x_r - ys;
        y_nxt = y_r + xs;
        z_nxt = z_r - ang;
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNTW'(CORDIC_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    z_r    <= z_nxt;
    cnt_r  <= cnt_nxt;
    zero_r <= zero_nxt;
  end

  assign done = done_r;
  assign z    = zero_r ? '0 : z_r;

endmodule

// ----- rtl/core/tpmd_div.sv -----
module tpmd_div
  import tpmd_pkg::*;
#(
  parameter int NW = 42
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic signed [NW-1:0] num,
  input  logic [DEN_W-1:0]     den,
  output logic                 done,
  output logic signed [NW-1:0] quo
);

  localparam int CNTW = $clog2(NW);

  logic [NW-1:0]    dvd_r, dvd_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt, den_r, den_nxt;
  logic [DEN_W:0]   trial;
  logic [CNTW-1:0]  cnt_r, cnt_nxt;
  logic             neg_r, neg_nxt, busy_r, busy_nxt, done_r, done_nxt;
  logic [NW-1:0]    mag;

  // rounds half away from zero: divide |num| + den/2
  assign mag   = (num < 0) ? NW'(-num) : NW'(num);
  assign trial = {rem_r, dvd_r[NW-1]};

  always_comb begin
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    neg_nxt  = neg_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      dvd_nxt  = mag + NW'(den >> 1);
      rem_nxt  = '0;
      den_nxt  = den;
      cnt_nxt  = '0;
      neg_nxt  = num < 0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = DEN_W'(trial - {1'b0, den_r});
        dvd_nxt = {dvd_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = DEN_W'(trial);
        dvd_nxt = {dvd_r[NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNTW'(NW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    cnt_r <= cnt_nxt;
    neg_r <= neg_nxt;
  end

  assign done = done_r;
  assign quo  = neg_r ? -signed'(dvd_r) : signed'(dvd_r);

endmodule

// ----- rtl/core/tpmd_mul.sv -----
module tpmd_mul
  import tpmd_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [GAIN_W-1:0]         gain_p,
  input  logic [GAIN_W-1:0]         gain_i,
  input  logic [GAIN_W-1:0]         gain_d,
  input  logic signed [STATE_W-1:0] err,
  input  logic signed [STATE_W-1:0] integ,
  input  logic signed [DER_W-1:0]   deriv,
  output logic                      done,
  output logic signed [SUM_W-1:0]   sum
);

  localparam int CNTW = $clog2(GAIN_W);

  // one bit of each gain per cycle, MSB first
  logic [GAIN_W-1:0]       gp_r, gp_nxt, gi_r, gi_nxt, gd_r, gd_nxt;
  logic signed [SUM_W-1:0] acc_r, acc_nxt, tp, ti, td;
  logic [CNTW-1:0]         cnt_r, cnt_nxt;
  logic                    busy_r, busy_nxt, done_r, done_nxt;

  assign tp = gp_r[GAIN_W-1] ? SUM_W'(err)   : '0;
  assign ti = gi_r[GAIN_W-1] ? SUM_W'(integ) : '0;
  assign td = gd_r[GAIN_W-1] ? SUM_W'(deriv) : '0;

  always_comb begin
    gp_nxt   = gp_r;
    gi_nxt   = gi_r;
    gd_nxt   = gd_r;
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      gp_nxt   = gain_p;
      gi_nxt   = gain_i;
      gd_nxt   = gain_d;
      acc_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      acc_nxt = (acc_r <<< 1) + tp + ti + td;
      gp_nxt  = gp_r << 1;
      gi_nxt  = gi_r << 1;
      gd_nxt  = gd_r << 1;
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNTW'(GAIN_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    gp_r  <= gp_nxt;
    gi_r  <= gi_nxt;
    gd_r  <= gd_nxt;
    acc_r <= acc_nxt;
    cnt_r <= cnt_nxt;
  end

  assign done = done_r;
  assign sum  = acc_r;

endmodule

// ----- rtl/core/tilt_pid_motor_drive_unit.sv -----
// One sample at a time: in_stall is high from accept until the result is registered for the
//   output, through the iterative CORDIC, the bit-serial divider (width DNW = max(16+FRAC_BITS, 34)
//   + 2) used three times, and the bit-serial PID multiply-accumulate; a held out_stall delays it.
// Reset (synchronous, rst_n low): controller idle, no result pending, gains and
//   floor to defaults, tilt/integral/previous error zero, seed pending.
module tilt_pid_motor_drive_unit
  import tpmd_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
  parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [SAMPLE_W-1:0] in_accel_x,
  input  logic signed [SAMPLE_W-1:0] in_accel_z,
  input  logic signed [SAMPLE_W-1:0] in_gyro_y,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [15:0]                out_drive_level,
  output logic                       out_forward,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data
);

  localparam int ZW  = FRAC_BITS + 10;
  localparam int DNW = ((SAMPLE_W + FRAC_BITS) > 34 ? (SAMPLE_W + FRAC_BITS) : 34) + 2;
  localparam int PSH = FRAC_BITS + 8;
  localparam logic signed [WIDE_W-1:0] LIM = WIDE_W'(100) <<< FRAC_BITS;

  tpmd_state_t state_r, state_nxt;

  logic [GAIN_W-1:0]          gain_p_r, gain_i_r, gain_d_r;
  logic signed [TARGET_W-1:0] target_r;
  logic [FLOOR_W-1:0]         floor_r;

  logic signed [SAMPLE_W-1:0] gy_r;
  logic signed [ZW-1:0]       acc_r;
  logic signed [STATE_W-1:0]  tilt_r, esum_r, prev_r, err_r;
  logic signed [DNW-1:0]      s_r;
  logic signed [DER_W-1:0]    deriv_r;
  logic                       seed_r;
  logic                       out_valid_r;
  logic [15:0]                out_drive_level_r;
  logic                       out_forward_r;
  // mul_go_r is set with the integral update and launches the multiply once it has landed
  logic                       mul_go_r;

  logic                       in_acc, out_free;
  logic                       cor_done, div_start, div_done, mul_start, mul_done;
  logic signed [ZW-1:0]       cor_z;
  logic signed [DNW-1:0]      div_num, div_quo, s_c;
  logic [DEN_W-1:0]           div_den;
  logic signed [SUM_W-1:0]    mul_sum;
  logic signed [STATE_W-1:0]  tilt_seed, err_c, integ_c;
  logic signed [WIDE_W-1:0]   isum;
  logic signed [DER_W-1:0]    dd;
  logic [SUM_W-1:0]           mag, floor_lim, pwm_hi;
  logic [7:0]                 pwm;

  assign in_acc    = in_valid && !in_stall;
  assign in_stall  = state_r != ST_IDLE;
  assign out_free  = !out_valid_r || !out_stall;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r <= GAIN_P_RST;
      gain_i_r <= GAIN_I_RST;
      gain_d_r <= GAIN_D_RST;
      target_r <= '0;
      floor_r  <= FLOOR_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_GAIN_P:       gain_p_r <= cfg_data[GAIN_W-1:0];
        REG_GAIN_I:       gain_i_r <= cfg_data[GAIN_W-1:0];
        REG_GAIN_D:       gain_d_r <= cfg_data[GAIN_W-1:0];
        REG_TARGET_ANGLE: target_r <= signed'(cfg_data);
        REG_PWM_FLOOR:    floor_r  <= cfg_data[FLOOR_W-1:0];
        default: ;
      endcase
    end
  end

  tpmd_cordic #(.CORDIC_STEPS(CORDIC_STEPS), .FRAC_BITS(FRAC_BITS)) u_cordic (
    .clk(clk), .rst_n(rst_n), .start(in_acc),
    .ax(in_accel_x), .az(in_accel_z), .done(cor_done), .z(cor_z)
  );

  tpmd_div #(.NW(DNW)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .num(div_num), .den(div_den), .done(div_done), .quo(div_quo)
  );

  tpmd_mul u_mul (
    .clk(clk), .rst_n(rst_n), .start(mul_start),
    .gain_p(gain_p_r), .gain_i(gain_i_r), .gain_d(gain_d_r),
    .err(err_r), .integ(esum_r), .deriv(deriv_r),
    .done(mul_done), .sum(mul_sum)
  );

  assign tilt_seed = seed_r ? sat32(WIDE_W'(cor_z)) : tilt_r;
  assign s_c       = DNW'(tilt_r) + div_quo;
  assign err_c     = sat32((WIDE_W'(target_r) <<< (FRAC_BITS - 8)) - WIDE_W'(tilt_r));
  assign isum      = WIDE_W'(esum_r) + WIDE_W'(div_quo);
  assign integ_c   = (isum > LIM)  ? STATE_W'(LIM)  :
                     (isum < -LIM) ? STATE_W'(-LIM) : isum[STATE_W-1:0];
  assign dd        = DER_W'(err_r) - DER_W'(prev_r);

  assign mag       = mul_sum[SUM_W-1] ? SUM_W'(-mul_sum) : SUM_W'(mul_sum);
  assign floor_lim = SUM_W'(floor_r) << PSH;
  assign pwm_hi    = mag >> PSH;
  always_comb begin
    if (mag != '0 && mag < floor_lim) pwm = floor_r;
    else if (|pwm_hi[SUM_W-1:8])     pwm = 8'hff;
    else                              pwm = pwm_hi[7:0];
  end

  always_comb begin
    state_nxt = state_r;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = DIV_GYRO;
    mul_start = mul_go_r;
    unique case (state_r)
      ST_IDLE:   if (in_acc) state_nxt = ST_CORDIC;
      ST_CORDIC: begin
        if (cor_done) begin
          div_start = 1'b1;
          div_num   = DNW'(gy_r) <<< FRAC_BITS;
          div_den   = DIV_GYRO;
          state_nxt = ST_GYRO;
        end
      end
      ST_GYRO: begin
        if (div_done) begin
          div_start = 1'b1;
          div_num   = DNW'(acc_r) - s_c;
          div_den   = DIV_BLEND;
          state_nxt = ST_BLEND;
        end
      end
      ST_BLEND:  if (div_done) state_nxt = ST_ERR;
      ST_ERR: begin
        div_start = 1'b1;
        div_num   = DNW'(err_c);
        div_den   = DIV_INTEG;
        state_nxt = ST_INTEG;
      end
      ST_INTEG:  if (div_done) state_nxt = ST_MUL;
      ST_MUL: begin
        // start pulse on entry, then wait for the accumulator
        if (mul_done) state_nxt = ST_OUT;
      end
      ST_OUT:    if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      seed_r      <= 1'b1;
      tilt_r      <= '0;
      esum_r      <= '0;
      prev_r      <= '0;
      out_valid_r <= 1'b0;
      mul_go_r    <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      mul_go_r <= state_r == ST_INTEG && div_done;
      if (state_r == ST_CORDIC && cor_done) begin
        tilt_r <= tilt_seed;
        seed_r <= 1'b0;
      end
      if (state_r == ST_BLEND && div_done) tilt_r <= sat32(WIDE_W'(s_r + div_quo));
      if (state_r == ST_INTEG && div_done) begin
        esum_r <= integ_c;
        prev_r <= err_r;
      end
      if (state_r == ST_OUT && out_free) out_valid_r <= 1'b1;
      else if (!out_stall)               out_valid_r <= 1'b0;
    end
    if (in_acc) gy_r <= in_gyro_y;
    if (state_r == ST_CORDIC && cor_done) acc_r <= cor_z;
    if (state_r == ST_GYRO && div_done) s_r <= s_c;
    if (state_r == ST_ERR) err_r <= err_c;
    if (state_r == ST_INTEG && div_done)
      deriv_r <= (dd <<< 7) + (dd <<< 6) + (dd <<< 3);
    if (state_r == ST_OUT && out_free) begin
      out_drive_level_r <= {pwm, 8'h00};
      out_forward_r     <= !mul_sum[SUM_W-1] && (mul_sum != '0);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_drive_level = out_drive_level_r;
  assign out_forward     = out_forward_r;

  a_integ_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (WIDE_W'(esum_r) <= LIM) && (WIDE_W'(esum_r) >= -LIM))
    else $error("integral out of clamp range");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == ST_CORDIC)
    else $error("accepted sample did not start the CORDIC");

  a_seed_once: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(seed_r) |-> $past(state_r) == ST_CORDIC)
    else $error("seed cleared outside the CORDIC step");

  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_OUT)
    else $error("result raised outside the output step");

endmodule
